>>> sv/piezo_hit_trigger_velocity_macros.svh
// Assertion helpers for the pad trigger. They expect clk and rst_n in scope.
`ifndef PIEZO_HIT_TRIGGER_VELOCITY_MACROS_SVH
`define PIEZO_HIT_TRIGGER_VELOCITY_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PHTV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PHTV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/phtv_pkg.sv
`default_nettype none
package phtv_pkg;

    localparam int SAMPLE_COUNT_DEF = 8;

    localparam int SAMPLE_W  = 10;
    localparam int NOTE_W    = 7;
    localparam int VEL_W     = 7;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // peak * 127 needs 17 bits; one quotient bit per divider step
    localparam int VEL_NUM_W = 17;
    localparam int DIV_CNT_W = 5;
    localparam logic [VEL_NUM_W-1:0] VEL_SCALE = 17'd127;

    localparam logic [CFG_IDX_W-1:0] REG_NOTE_NUMBER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_LENGTH_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MAX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VOLUME     = 3'd5;

    localparam logic [NOTE_W-1:0]   RST_NOTE_NUMBER    = 7'd36;
    localparam logic [TIME_W-1:0]   RST_DEBOUNCE_MS    = 32'd30;
    localparam logic [TIME_W-1:0]   RST_NOTE_LENGTH_MS = 32'd100;
    localparam logic [SAMPLE_W-1:0] RST_SENSOR_MIN     = 10'd20;
    localparam logic [SAMPLE_W-1:0] RST_SENSOR_MAX     = 10'd1023;
    localparam logic [VEL_W-1:0]    RST_MIN_VOLUME     = 7'd2;

    localparam logic EV_ON  = 1'b0;
    localparam logic EV_OFF = 1'b1;

    typedef struct packed {
        logic [NOTE_W-1:0]   note_number;
        logic [TIME_W-1:0]   debounce_ms;
        logic [TIME_W-1:0]   note_length_ms;
        logic [SAMPLE_W-1:0] sensor_min;
        logic [SAMPLE_W-1:0] sensor_max;
        logic [VEL_W-1:0]    min_volume;
    } cfg_t;

    // microcode
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE     = 4'd0;
    localparam step_t STEP_SCAN     = 4'd1;
    localparam step_t STEP_THIRDS   = 4'd2;
    localparam step_t STEP_HIT      = 4'd3;
    localparam step_t STEP_DIV      = 4'd4;
    localparam step_t STEP_FIRE     = 4'd5;
    localparam step_t STEP_TMO      = 4'd6;
    localparam step_t STEP_EMIT_OFF = 4'd7;
    localparam step_t STEP_EMIT_ON  = 4'd8;
    localparam step_t STEP_EMIT_TMO = 4'd9;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_SCAN,
        OP_THIRDS,
        OP_HIT,
        OP_DIV,
        OP_FIRE,
        OP_TMO
    } op_t;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_OFF_FIRST,
        EM_ON,
        EM_TMO
    } emit_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_WAIT_IN,
        C_SCAN_MORE,
        C_DIV_MORE
    } cond_t;

    typedef struct packed {
        op_t   op;
        emit_t emit;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic scan_more;
        logic div_more;
        logic emit_stall;
    } stat_t;

    function automatic ctrl_t prog_rom(input step_t s);
        ctrl_t w;
        w = '{op: OP_NOP, emit: EM_NONE, cond: C_NEXT, target: STEP_IDLE};
        case (s)
            STEP_IDLE:     w = '{op: OP_LOAD,   emit: EM_NONE,      cond: C_WAIT_IN,
                                 target: STEP_IDLE};
            STEP_SCAN:     w = '{op: OP_SCAN,   emit: EM_NONE,      cond: C_SCAN_MORE,
                                 target: STEP_SCAN};
            STEP_THIRDS:   w = '{op: OP_THIRDS, emit: EM_NONE,      cond: C_NEXT,
                                 target: STEP_IDLE};
            STEP_HIT:      w = '{op: OP_HIT,    emit: EM_NONE,      cond: C_NEXT,
                                 target: STEP_IDLE};
            STEP_DIV:      w = '{op: OP_DIV,    emit: EM_NONE,      cond: C_DIV_MORE,
                                 target: STEP_DIV};
            STEP_FIRE:     w = '{op: OP_FIRE,   emit: EM_NONE,      cond: C_NEXT,
                                 target: STEP_IDLE};
            STEP_TMO:      w = '{op: OP_TMO,    emit: EM_NONE,      cond: C_NEXT,
                                 target: STEP_IDLE};
            STEP_EMIT_OFF: w = '{op: OP_NOP,    emit: EM_OFF_FIRST, cond: C_NEXT,
                                 target: STEP_IDLE};
            STEP_EMIT_ON:  w = '{op: OP_NOP,    emit: EM_ON,        cond: C_NEXT,
                                 target: STEP_IDLE};
            STEP_EMIT_TMO: w = '{op: OP_NOP,    emit: EM_TMO,       cond: C_JUMP,
                                 target: STEP_IDLE};
            default:       w = '{op: OP_NOP,    emit: EM_NONE,      cond: C_JUMP,
                                 target: STEP_IDLE};
        endcase
        return w;
    endfunction

    // floor(x / 3) for x below 2048: multiply by 683 and drop 11 bits
    function automatic logic [SAMPLE_W-1:0] third10(input logic [SAMPLE_W-1:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'd683;
        return p[20:11];
    endfunction

endpackage
`default_nettype wire

>>> sv/phtv_seq.sv
`default_nettype none
`include "piezo_hit_trigger_velocity_macros.svh"
module phtv_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  phtv_pkg::stat_t stat,
    output phtv_pkg::ctrl_t ctrl,
    output logic            in_ready
);
    import phtv_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  take_jump;

    assign ctrl     = prog_rom(step_reg);
    assign in_ready = (ctrl.op == OP_LOAD);

    always_comb
    begin
        case (ctrl.cond)
            C_NEXT:      take_jump = 1'b0;
            C_JUMP:      take_jump = 1'b1;
            C_WAIT_IN:   take_jump = !in_valid;
            C_SCAN_MORE: take_jump = stat.scan_more;
            C_DIV_MORE:  take_jump = stat.div_more;
            default:     take_jump = 1'b1;
        endcase
    end

    always_comb
    begin
        if (stat.emit_stall)
        begin
            // hold until the output register frees up
            step_next = step_reg;
        end
        else if (take_jump)
        begin
            step_next = ctrl.target;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    `PHTV_ASSERT_NEXT(a_stall_holds_step, stat.emit_stall, step_reg == $past(step_reg), "step moved while stalled")
    `PHTV_ASSERT_NEXT(a_accept_starts_scan, in_valid && in_ready, step_reg == STEP_SCAN, "request did not start scan")
    `PHTV_ASSERT_NOW(a_step_in_program, 1'b1, step_reg <= STEP_EMIT_TMO, "step counter left the program")

endmodule
`default_nettype wire

>>> sv/phtv_datapath.sv
`default_nettype none
`include "piezo_hit_trigger_velocity_macros.svh"
module phtv_datapath #(
    parameter int SAMPLE_COUNT = phtv_pkg::SAMPLE_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  phtv_pkg::ctrl_t                 ctrl,
    input  phtv_pkg::cfg_t                  cfg,
    input  logic                            in_valid,
    input  logic [phtv_pkg::SAMPLE_W-1:0]   adc_sample,
    input  logic [phtv_pkg::SAMPLE_W-1:0]   left_peak,
    input  logic [phtv_pkg::SAMPLE_W-1:0]   right_peak,
    input  logic [phtv_pkg::TIME_W-1:0]     now_ms,
    input  logic                            out_ready,
    output phtv_pkg::stat_t                 stat,
    output logic                            out_valid,
    output logic                            event_kind,
    output logic [phtv_pkg::NOTE_W-1:0]     note,
    output logic [phtv_pkg::VEL_W-1:0]      velocity,
    output logic                            led_on,
    output logic                            last
);
    import phtv_pkg::*;

    localparam int IW = $clog2(SAMPLE_COUNT);
    localparam logic [IW-1:0] LAST_IDX = IW'(SAMPLE_COUNT - 1);

    // ring memory, entries not yet written are left out of the peak scan
    logic [SAMPLE_W-1:0]     ring [SAMPLE_COUNT];
    logic [SAMPLE_COUNT-1:0] valid_reg, valid_next;
    logic [IW-1:0]           slot_reg, slot_next;
    logic [IW-1:0]           idx_reg, idx_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic [SAMPLE_W-1:0]     rd_data_reg;
    logic                    rd_ok_reg;

    logic [SAMPLE_W-1:0]  left_reg, right_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [SAMPLE_W-1:0]  peak_reg, peak_next;
    logic [SAMPLE_W-1:0]  left3_reg, left3_next;
    logic [SAMPLE_W-1:0]  right3_reg, right3_next;
    logic [VEL_W-1:0]     prior3_reg, prior3_next;
    logic                 hit_ok_reg, hit_ok_next;
    logic [VEL_NUM_W-1:0] dvd_reg, dvd_next;
    logic [SAMPLE_W-1:0]  rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [VEL_W-1:0]     vel_reg, vel_next;
    logic                 fire_reg, fire_next;
    logic                 off1_reg, off1_next;
    logic                 tmo_reg, tmo_next;

    logic [TIME_W-1:0]    hit_time_reg, hit_time_next;
    logic                 sounding_reg, sounding_next;
    logic [VEL_W-1:0]     prior_vel_reg, prior_vel_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 kind_reg, kind_next;
    logic [NOTE_W-1:0]    note_reg, note_next;
    logic [VEL_W-1:0]     ovel_reg, ovel_next;
    logic                 led_reg, led_next;
    logic                 last_reg, last_next;

    logic                 accept;
    logic                 emit_flag;
    logic                 out_free;
    logic                 load_out;

    // combinational helpers
    logic                 hit;
    logic [SAMPLE_W-1:0]  peak_c;
    logic [SAMPLE_W:0]    trial;
    logic [SAMPLE_W:0]    diff;
    logic [VEL_W-1:0]     vel_cur;
    logic [TIME_W-1:0]    deb_sum;
    logic [TIME_W-1:0]    len_sum;
    logic [SAMPLE_W-1:0]  prior3_wide;

    assign accept = (ctrl.op == OP_LOAD) && in_valid;

    assign hit = (peak_reg > left3_reg) && (peak_reg > right3_reg)
                 && (peak_reg > cfg.sensor_min);
    assign peak_c  = (peak_reg > cfg.sensor_max) ? cfg.sensor_max : peak_reg;
    assign trial   = {rem_reg, dvd_reg[VEL_NUM_W-1]};
    assign diff    = trial - {1'b0, cfg.sensor_max};
    assign vel_cur = hit_ok_reg ? dvd_reg[VEL_W-1:0] : '0;
    assign deb_sum = hit_time_reg + cfg.debounce_ms;
    assign len_sum = hit_time_reg + cfg.note_length_ms;
    assign prior3_wide = third10({3'b000, prior_vel_reg});

    always_comb
    begin
        case (ctrl.emit)
            EM_OFF_FIRST: emit_flag = off1_reg;
            EM_ON:        emit_flag = fire_reg;
            EM_TMO:       emit_flag = tmo_reg;
            default:      emit_flag = 1'b0;
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;
    assign load_out = emit_flag && out_free;

    assign stat.scan_more  = (idx_reg != LAST_IDX);
    assign stat.div_more   = (div_cnt_reg != DIV_CNT_W'(1));
    assign stat.emit_stall = emit_flag && !out_free;

    always_comb
    begin
        valid_next     = valid_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        rd_pend_next   = (ctrl.op == OP_SCAN);
        peak_next      = peak_reg;
        left3_next     = left3_reg;
        right3_next    = right3_reg;
        prior3_next    = prior3_reg;
        hit_ok_next    = hit_ok_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        vel_next       = vel_reg;
        fire_next      = fire_reg;
        off1_next      = off1_reg;
        tmo_next       = tmo_reg;
        hit_time_next  = hit_time_reg;
        sounding_next  = sounding_reg;
        prior_vel_next = prior_vel_reg;

        // fold the registered ring read into the running maximum
        if (rd_pend_reg && rd_ok_reg && (rd_data_reg > peak_reg))
        begin
            peak_next = rd_data_reg;
        end

        case (ctrl.op)
            OP_LOAD:
            begin
                if (accept)
                begin
                    valid_next[slot_reg] = 1'b1;
                    slot_next = (slot_reg == LAST_IDX) ? '0 : slot_reg + 1'b1;
                    idx_next  = '0;
                    peak_next = '0;
                end
            end
            OP_SCAN:
            begin
                idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
            end
            OP_THIRDS:
            begin
                left3_next  = third10(left_reg);
                right3_next = third10(right_reg);
                prior3_next = prior3_wide[VEL_W-1:0];
            end
            OP_HIT:
            begin
                hit_ok_next  = hit && (cfg.sensor_max != '0);
                dvd_next     = (hit && (cfg.sensor_max != '0))
                               ? VEL_NUM_W'(peak_c) * VEL_SCALE : '0;
                rem_next     = '0;
                div_cnt_next = DIV_CNT_W'(VEL_NUM_W);
            end
            OP_DIV:
            begin
                // restoring divide, one quotient bit per step
                if (!diff[SAMPLE_W])
                begin
                    rem_next = diff[SAMPLE_W-1:0];
                    dvd_next = {dvd_reg[VEL_NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[SAMPLE_W-1:0];
                    dvd_next = {dvd_reg[VEL_NUM_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - 1'b1;
            end
            OP_FIRE:
            begin
                vel_next  = vel_cur;
                fire_next = (vel_cur > cfg.min_volume) && (vel_cur > prior3_reg)
                            && (now_reg > deb_sum);
                off1_next = 1'b0;
                if ((vel_cur > cfg.min_volume) && (vel_cur > prior3_reg)
                    && (now_reg > deb_sum))
                begin
                    off1_next      = sounding_reg;
                    hit_time_next  = now_reg;
                    sounding_next  = 1'b1;
                    prior_vel_next = vel_cur;
                end
            end
            OP_TMO:
            begin
                tmo_next = sounding_reg && (now_reg >= len_sum);
                if (sounding_reg && (now_reg >= len_sum))
                begin
                    sounding_next  = 1'b0;
                    prior_vel_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        note_next      = note_reg;
        ovel_next      = ovel_reg;
        led_next       = led_reg;
        last_next      = last_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            note_next      = cfg.note_number;
            case (ctrl.emit)
                EM_OFF_FIRST:
                begin
                    // indicator stays lit through a retrigger
                    kind_next = EV_OFF;
                    ovel_next = '0;
                    led_next  = 1'b1;
                    last_next = 1'b0;
                end
                EM_ON:
                begin
                    kind_next = EV_ON;
                    ovel_next = vel_reg;
                    led_next  = 1'b1;
                    last_next = !tmo_reg;
                end
                default:
                begin
                    kind_next = EV_OFF;
                    ovel_next = '0;
                    led_next  = 1'b0;
                    last_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring[slot_reg] <= adc_sample;
        end
        if (ctrl.op == OP_SCAN)
        begin
            rd_data_reg <= ring[idx_reg];
            rd_ok_reg   <= valid_reg[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            slot_reg      <= '0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            div_cnt_reg   <= '0;
            hit_time_reg  <= '0;
            sounding_reg  <= 1'b0;
            prior_vel_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            slot_reg      <= slot_next;
            idx_reg       <= idx_next;
            rd_pend_reg   <= rd_pend_next;
            div_cnt_reg   <= div_cnt_next;
            hit_time_reg  <= hit_time_next;
            sounding_reg  <= sounding_next;
            prior_vel_reg <= prior_vel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg  <= left_peak;
            right_reg <= right_peak;
            now_reg   <= now_ms;
        end
        peak_reg   <= peak_next;
        left3_reg  <= left3_next;
        right3_reg <= right3_next;
        prior3_reg <= prior3_next;
        hit_ok_reg <= hit_ok_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        vel_reg    <= vel_next;
        fire_reg   <= fire_next;
        off1_reg   <= off1_next;
        tmo_reg    <= tmo_next;
        kind_reg   <= kind_next;
        note_reg   <= note_next;
        ovel_reg   <= ovel_next;
        led_reg    <= led_next;
        last_reg   <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = kind_reg;
    assign note       = note_reg;
    assign velocity   = ovel_reg;
    assign led_on     = led_reg;
    assign last       = last_reg;

    `PHTV_ASSERT_NOW(a_off_has_no_velocity, out_valid_reg && (kind_reg == EV_OFF), ovel_reg == '0, "note off with velocity")
    `PHTV_ASSERT_NOW(a_retrigger_off_not_last, out_valid_reg && (kind_reg == EV_OFF) && led_reg, !last_reg, "retrigger note off marked last")
    `PHTV_ASSERT_NOW(a_div_count_live, ctrl.op == OP_DIV, div_cnt_reg != '0, "divider ran past its count")

endmodule
`default_nettype wire

>>> sv/piezo_hit_trigger_velocity.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    adc_sample, left_peak, right_peak, now_ms
// out       out_valid / out_ready  event_kind, note, velocity, led_on, last
// cfg       cfg_we (no wait)       cfg_index, cfg_data
//
// A request runs through the steps in order: the peak scan reads one ring entry
// per step (single read port), a restoring divide forms the velocity one
// quotient bit per step, and each possible result has its own emit step.
// A stalled output holds the sequencer on its emit step; the input is taken
// only at the idle step. Reset clears the ring through per-entry valid bits.
`default_nettype none
module piezo_hit_trigger_velocity #(
    parameter int SAMPLE_COUNT = phtv_pkg::SAMPLE_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [phtv_pkg::SAMPLE_W-1:0]     adc_sample,
    input  logic [phtv_pkg::SAMPLE_W-1:0]     left_peak,
    input  logic [phtv_pkg::SAMPLE_W-1:0]     right_peak,
    input  logic [phtv_pkg::TIME_W-1:0]       now_ms,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              event_kind,
    output logic [phtv_pkg::NOTE_W-1:0]       note,
    output logic [phtv_pkg::VEL_W-1:0]        velocity,
    output logic                              led_on,
    output logic                              last,
    input  logic                              cfg_we,
    input  logic [phtv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [phtv_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import phtv_pkg::*;

    cfg_t  cfg_reg;
    ctrl_t ctrl;
    stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.note_number    <= RST_NOTE_NUMBER;
            cfg_reg.debounce_ms    <= RST_DEBOUNCE_MS;
            cfg_reg.note_length_ms <= RST_NOTE_LENGTH_MS;
            cfg_reg.sensor_min     <= RST_SENSOR_MIN;
            cfg_reg.sensor_max     <= RST_SENSOR_MAX;
            cfg_reg.min_volume     <= RST_MIN_VOLUME;
        end
        else if (cfg_we)
        begin
            // drop writes to unknown indexes
            case (cfg_index)
                REG_NOTE_NUMBER:    cfg_reg.note_number    <= cfg_data[NOTE_W-1:0];
                REG_DEBOUNCE_MS:    cfg_reg.debounce_ms    <= cfg_data[TIME_W-1:0];
                REG_NOTE_LENGTH_MS: cfg_reg.note_length_ms <= cfg_data[TIME_W-1:0];
                REG_SENSOR_MIN:     cfg_reg.sensor_min     <= cfg_data[SAMPLE_W-1:0];
                REG_SENSOR_MAX:     cfg_reg.sensor_max     <= cfg_data[SAMPLE_W-1:0];
                REG_MIN_VOLUME:     cfg_reg.min_volume     <= cfg_data[VEL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    phtv_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .ctrl     (ctrl),
        .in_ready (in_ready)
    );

    phtv_datapath #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .adc_sample (adc_sample),
        .left_peak  (left_peak),
        .right_peak (right_peak),
        .now_ms     (now_ms),
        .out_ready  (out_ready),
        .stat       (stat),
        .out_valid  (out_valid),
        .event_kind (event_kind),
        .note       (note),
        .velocity   (velocity),
        .led_on     (led_on),
        .last       (last)
    );

endmodule
`default_nettype wire
